>>> design/mrpr_pkg.sv
// ----------------------------------------------------------------------------
// mrpr_pkg
// Shared constants and types for the Miller-Rabin round engine.
// ----------------------------------------------------------------------------
package mrpr_pkg;

    // width of the candidate as it is judged (low bits of the candidate port)
    localparam int NUMBER_BITS = 32;
    // width of the raw random word
    localparam int WORD_W      = 32;
    // counter widths
    localparam int MM_CNT_W    = $clog2(WORD_W + 1);
    localparam int EXP_CNT_W   = $clog2(NUMBER_BITS + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_GO,
        ST_WAIT,
        ST_STRIP,
        ST_EXP,
        ST_TEST,
        ST_VERDICT
    } t_state;

    // operation issued to the shared modular multiplier
    typedef enum logic [1:0] {
        OP_DIV,
        OP_SQ,
        OP_MUL,
        OP_CSQ
    } t_op;

endpackage

>>> design/mrpr_modmul.sv
// ----------------------------------------------------------------------------
// mrpr_modmul
// Bit-serial interleaved modular multiplier: product = (x * y) mod m,
// one bit of y per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module mrpr_modmul
    import mrpr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [NUMBER_BITS-1:0] i_x,
    input  logic [WORD_W-1:0]      i_y,
    input  logic [NUMBER_BITS-1:0] i_m,
    output logic                   o_done,
    output logic [NUMBER_BITS-1:0] o_product
);

    logic                   r_busy;
    logic                   r_done;
    logic [MM_CNT_W-1:0]    r_cnt;
    logic [NUMBER_BITS-1:0] r_acc;
    logic [NUMBER_BITS-1:0] r_x;
    logic [WORD_W-1:0]      r_y;
    logic [NUMBER_BITS-1:0] r_m;

    logic [NUMBER_BITS+1:0] sum;
    logic [NUMBER_BITS+1:0] m1;
    logic [NUMBER_BITS+1:0] m2;
    logic [NUMBER_BITS-1:0] n_acc;

    // acc < m and x <= m keep the sum below 3m, so two trial subtractions do
    always_comb begin
        m1  = {2'b00, r_m};
        m2  = {1'b0, r_m, 1'b0};
        sum = {1'b0, r_acc, 1'b0} + (r_y[WORD_W-1] ? {2'b00, r_x} : '0);
        if (sum >= m2) begin
            n_acc = NUMBER_BITS'(sum - m2);
        end else if (sum >= m1) begin
            n_acc = NUMBER_BITS'(sum - m1);
        end else begin
            n_acc = NUMBER_BITS'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == MM_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= MM_CNT_W'(WORD_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_acc <= n_acc;
            r_y   <= {r_y[WORD_W-2:0], 1'b0};
        end else if (i_start) begin
            r_acc <= '0;
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt != MM_CNT_W'(WORD_W)) |-> (r_acc < r_m))
        else $error("modmul accumulator not reduced");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("modmul done longer than one cycle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !r_busy) |=> (r_busy && r_cnt == MM_CNT_W'(WORD_W)))
        else $error("modmul did not start");

endmodule

>>> design/miller_rabin_primality_round.sv
// ----------------------------------------------------------------------------
// miller_rabin_primality_round
// One Miller-Rabin round per input beat, verdicts ANDed until the last round.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready): candidate, raw random word and a
// last-round mark. One round is worked at a time; o_ready is high only
// while the engine is idle.
// Output channel (o_valid / i_ready): one beat per last round, carrying
// probably_prime. The result sits in an output register, so the engine
// takes the next round while an earlier verdict still waits.
// Trivial candidates (two, even, below two) go from classification
// straight to the verdict. Otherwise every step goes through one shared
// bit-serial modular multiplier: one operation for the witness
// reduction, up to 2*NUMBER_BITS for the power, up to NUMBER_BITS-3 for
// the closing squarings, after the twos are stripped from n-1 bit by bit.
// Reset clears the running flag to "no round failed" and empties the
// output register. If the receiver stalls with a verdict still held, a
// further last round waits in its verdict step until the register frees.
// ----------------------------------------------------------------------------
module miller_rabin_primality_round
    import mrpr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_candidate,
    input  logic [31:0]        i_random_word,
    input  logic               i_last_round,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_probably_prime
);

    t_state r_state;
    t_state n_state;

    logic                   r_pass;
    logic                   r_out_valid;
    logic                   r_out_prime;

    logic [NUMBER_BITS-1:0] r_n;
    logic [WORD_W-1:0]      r_word;
    logic                   r_last;
    logic [NUMBER_BITS-1:0] r_a;
    logic [NUMBER_BITS-1:0] r_e;
    logic [NUMBER_BITS-1:0] r_y;
    logic [EXP_CNT_W-1:0]   r_ecnt;
    logic [EXP_CNT_W-1:0]   r_s;
    logic                   r_ok;
    logic                   r_loop;
    t_op                    r_op;

    logic                   mm_start;
    logic                   mm_done;
    logic [NUMBER_BITS-1:0] mm_x;
    logic [WORD_W-1:0]      mm_y;
    logic [NUMBER_BITS-1:0] mm_m;
    logic [NUMBER_BITS-1:0] mm_p;

    logic [NUMBER_BITS-1:0] nm1;
    logic                   trivial;
    logic                   is_two;
    logic                   test_pass;
    logic                   test_fail;
    logic                   emit_ok;
    logic                   pass_new;

    assign nm1      = r_n - 1'b1;
    assign is_two   = (r_n == NUMBER_BITS'(2));
    // two passes; negative, even or one fails
    assign trivial  = is_two || r_n[NUMBER_BITS-1] || !r_n[0] || (r_n == NUMBER_BITS'(1));
    assign test_pass = (r_y == nm1) || (!r_loop && r_y == NUMBER_BITS'(1));
    assign test_fail = !test_pass && ((r_y == NUMBER_BITS'(1)) || (r_s == EXP_CNT_W'(1)));
    assign emit_ok   = !r_out_valid || i_ready;
    assign pass_new  = r_pass && r_ok;

    mrpr_modmul u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mm_start),
        .i_x       (mm_x),
        .i_y       (mm_y),
        .i_m       (mm_m),
        .o_done    (mm_done),
        .o_product (mm_p)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) n_state = ST_CLASS;
            end
            ST_CLASS: begin
                n_state = trivial ? ST_VERDICT : ST_GO;
            end
            ST_GO: begin
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                if (mm_done) begin
                    unique case (r_op)
                        OP_DIV: n_state = ST_STRIP;
                        OP_SQ:  n_state = r_e[NUMBER_BITS-1] ? ST_GO : ST_EXP;
                        OP_MUL: n_state = ST_EXP;
                        OP_CSQ: n_state = ST_TEST;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_STRIP: begin
                if (r_e[0]) n_state = ST_EXP;
            end
            ST_EXP: begin
                n_state = (r_ecnt == '0) ? ST_TEST : ST_GO;
            end
            ST_TEST: begin
                n_state = (test_pass || test_fail) ? ST_VERDICT : ST_GO;
            end
            ST_VERDICT: begin
                if (!r_last || emit_ok) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and multiplier operand select
    always_comb begin
        o_ready  = (r_state == ST_IDLE);
        mm_start = (r_state == ST_GO);
        mm_x     = r_y;
        mm_y     = WORD_W'(r_y);
        mm_m     = r_n;
        unique case (r_op)
            OP_DIV: begin
                // word mod (n-2) as word * 1 mod (n-2)
                mm_x = NUMBER_BITS'(1);
                mm_y = r_word;
                mm_m = r_n - NUMBER_BITS'(2);
            end
            OP_MUL: begin
                mm_y = WORD_W'(r_a);
            end
            OP_SQ, OP_CSQ: begin
                mm_y = WORD_W'(r_y);
            end
            default: begin
                mm_y = WORD_W'(r_y);
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pass      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // a new verdict may replace the one taken in the same cycle
            if (r_state == ST_VERDICT && r_last && emit_ok) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_VERDICT) begin
                if (!r_last) begin
                    r_pass <= pass_new;
                end else if (emit_ok) begin
                    r_pass <= 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    r_n    <= i_candidate[NUMBER_BITS-1:0];
                    r_word <= i_random_word;
                    r_last <= i_last_round;
                end
            end
            ST_CLASS: begin
                r_ok   <= is_two;
                r_e    <= nm1;
                r_s    <= '0;
                r_op   <= OP_DIV;
                r_loop <= 1'b0;
            end
            ST_WAIT: begin
                if (mm_done) begin
                    unique case (r_op)
                        OP_DIV: begin
                            r_a <= mm_p + 1'b1;
                        end
                        OP_SQ: begin
                            r_y <= mm_p;
                            if (r_e[NUMBER_BITS-1]) begin
                                r_op <= OP_MUL;
                            end else begin
                                r_e    <= {r_e[NUMBER_BITS-2:0], 1'b0};
                                r_ecnt <= r_ecnt - 1'b1;
                            end
                        end
                        OP_MUL: begin
                            r_y    <= mm_p;
                            r_e    <= {r_e[NUMBER_BITS-2:0], 1'b0};
                            r_ecnt <= r_ecnt - 1'b1;
                            r_op   <= OP_SQ;
                        end
                        OP_CSQ: begin
                            r_y <= mm_p;
                        end
                        default: begin
                            r_y <= mm_p;
                        end
                    endcase
                end
            end
            ST_STRIP: begin
                if (!r_e[0]) begin
                    r_e <= {1'b0, r_e[NUMBER_BITS-1:1]};
                    r_s <= r_s + 1'b1;
                end else begin
                    // left-to-right power over all bits, starting from one
                    r_y    <= NUMBER_BITS'(1);
                    r_ecnt <= EXP_CNT_W'(NUMBER_BITS);
                    r_op   <= OP_SQ;
                end
            end
            ST_TEST: begin
                r_ok <= test_pass;
                if (!test_pass && !test_fail) begin
                    r_s    <= r_s - 1'b1;
                    r_loop <= 1'b1;
                    r_op   <= OP_CSQ;
                end
            end
            ST_VERDICT: begin
                if (r_last && emit_ok) r_out_prime <= pass_new;
            end
            default: begin
            end
        endcase
    end

    assign o_valid          = r_out_valid;
    assign o_probably_prime = r_out_prime;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> (r_state == ST_WAIT))
        else $error("multiplier result outside wait state");

    a_flag_rearmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VERDICT && r_last && emit_ok) |=> (r_pass && r_out_valid))
        else $error("running flag not rearmed after emission");

    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_VERDICT && $past(r_last)))
        else $error("verdict emitted outside a last round");

endmodule
